// ===== rtl/utrx_pkg.sv =====
// Package for the UART transceiver with receive ring: frame phase codes,
// receive event codes, parity modes, configuration register indexes and defaults.
// No dependencies.
package utrx_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_RING_DEPTH      = 8;
    localparam int DEF_TICK_COUNT_BITS = 16;

    // Field widths fixed by the interface.
    localparam int PERIOD_W = 16;
    localparam int LEAD_W   = 16;
    localparam int PMODE_W  = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Reset values of the configuration registers.
    localparam logic [PERIOD_W-1:0] RST_BIT_PERIOD  = 16'd2500;
    localparam logic [LEAD_W-1:0]   RST_SAMPLE_LEAD = 16'd48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LEAD = 2'd3;

    // Parity modes. The unused fourth code behaves as odd parity.
    localparam logic [PMODE_W-1:0] PAR_NONE    = 2'd0;
    localparam logic [PMODE_W-1:0] PAR_ODD     = 2'd1;
    localparam logic [PMODE_W-1:0] PAR_EVEN    = 2'd2;
    localparam logic [PMODE_W-1:0] PAR_ODD_ALT = 2'd3;

    // Frame phases, shared by transmitter and receiver.
    typedef logic [3:0] phase_t;
    localparam phase_t PH_IDLE   = 4'd0;
    localparam phase_t PH_START  = 4'd1;
    localparam phase_t PH_DATA0  = 4'd2;
    localparam phase_t PH_DATA7  = 4'd9;
    localparam phase_t PH_PARITY = 4'd10;
    localparam phase_t PH_STOP   = 4'd11;
    localparam phase_t PH_AFTER  = 4'd12;

    // Receive events.
    typedef logic [1:0] rx_event_t;
    localparam rx_event_t EV_NONE    = 2'd0;
    localparam rx_event_t EV_STORED  = 2'd1;
    localparam rx_event_t EV_ERROR   = 2'd2;
    localparam rx_event_t EV_DROPPED = 2'd3;

endpackage

// ===== rtl/uart_transceiver_with_rx_fifo.sv =====
// A request is registered in the input register on acceptance; its result is
// registered in the output register when the input register advances.
// Throughput: one request per cycle while results are taken; the frame state and ring update once per request.
// Reset (aresetn, synchronous, active low) clears control state and the ring
// valid bits, and restores the configuration registers to their defaults.
// The module holds the whole UART transceiver and depends on utrx_pkg.
module uart_transceiver_with_rx_fifo
    import utrx_pkg::*;
#(
    parameter int RING_DEPTH      = DEF_RING_DEPTH,
    parameter int TICK_COUNT_BITS = DEF_TICK_COUNT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input requests, one per timer tick.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] rx_level, [1] send_valid, [9:2] send_byte, [10] read_req, [15:11] zero
    input  logic [15:0]          s_tdata,
    // Results, one per request.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] tx_level, [1] tx_busy, [9:2] read_data, [10] char_available,
    // [12:11] rx_event, [15:13] zero
    output logic [15:0]          m_tdata,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = TICK_COUNT_BITS;
    // Comparison width covers both the tick counters and the 16-bit period.
    localparam int CMP_W = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic                enable_reg;
    logic [PERIOD_W-1:0] bit_period_reg;
    logic [PMODE_W-1:0]  parity_mode_reg;
    logic [LEAD_W-1:0]   sample_lead_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b0;
            bit_period_reg  <= RST_BIT_PERIOD;
            parity_mode_reg <= PAR_NONE;
            sample_lead_reg <= RST_SAMPLE_LEAD;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENABLE:      enable_reg      <= cfg_wdata[0];
                CFG_BIT_PERIOD:  bit_period_reg  <= cfg_wdata[PERIOD_W-1:0];
                CFG_PARITY_MODE: parity_mode_reg <= cfg_wdata[PMODE_W-1:0];
                CFG_SAMPLE_LEAD: sample_lead_reg <= cfg_wdata[LEAD_W-1:0];
                default:         enable_reg      <= enable_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: an input register feeds the tick logic, whose result lands
    // in an output register. The input register advances whenever the
    // output register is empty or being drained, and a new request is taken
    // as the held one advances, but not while a finished result waits downstream.
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic [10:0] in_data_reg;
    logic        m_tvalid_reg;
    logic [12:0] m_tdata_reg;
    logic        advance;
    logic        s_fire;

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_tdata_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_tdata[10:0];
        end
    end

    // Unpacked fields of the registered request.
    logic       rx_level;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       read_req;

    assign rx_level   = in_data_reg[0];
    assign send_valid = in_data_reg[1];
    assign send_byte  = in_data_reg[9:2];
    assign read_req   = in_data_reg[10];

    // ------------------------------------------------------------------
    // Frame and ring state.
    // ------------------------------------------------------------------
    logic [7:0]       tx_shift_reg,      tx_shift_next;
    phase_t           tx_phase_reg,      tx_phase_next;
    logic [CNT_W-1:0] tx_tick_count_reg, tx_tick_count_next;
    logic             tx_parity_bit_reg, tx_parity_bit_next;
    phase_t           rx_phase_reg,      rx_phase_next;
    logic [CNT_W-1:0] rx_tick_count_reg, rx_tick_count_next;
    logic [7:0]       rx_shift_reg,      rx_shift_next;
    logic             rx_ones_parity_reg, rx_ones_parity_next;
    logic             rx_prev_level_reg;
    logic [PTR_W-1:0] ring_head_reg,     ring_head_next;
    logic [PTR_W-1:0] ring_tail_reg,     ring_tail_next;

    // Ring storage. The entry at the head is read one tick ahead into
    // rd_q_reg; entries never written read as zero through the valid bits.
    logic [7:0]       ring_mem [RING_DEPTH];
    logic             ring_vld_reg [RING_DEPTH];
    logic [7:0]       rd_q_reg;
    logic             rd_valid_reg;
    logic             ring_wr;
    logic             rd_fwd;

    function automatic logic [PTR_W-1:0] ring_nxt(input logic [PTR_W-1:0] idx);
        return (idx == PTR_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Effective period and sample position within a bit slot.
    logic [PERIOD_W-1:0] eff_period;
    logic [PERIOD_W-1:0] samp_pos;
    assign eff_period = (bit_period_reg == '0) ? PERIOD_W'(1) : bit_period_reg;
    assign samp_pos   = (sample_lead_reg >= eff_period) ? '0
                      : eff_period - PERIOD_W'(1) - sample_lead_reg;

    // Outputs of the tick.
    logic       tx_level;
    logic       tx_busy;
    logic [7:0] read_data;
    logic       char_available;
    rx_event_t  rx_event;

    logic [CNT_W-1:0] tx_cnt_inc;
    logic [CNT_W-1:0] rx_cnt_inc;
    logic [3:0]       tx_bit_off;
    logic [3:0]       rx_bit_off;
    logic             rx_start;
    logic             rx_bad;
    logic             rx_done;

    always_comb begin
        tx_shift_next       = tx_shift_reg;
        tx_phase_next       = tx_phase_reg;
        tx_tick_count_next  = tx_tick_count_reg;
        tx_parity_bit_next  = tx_parity_bit_reg;
        rx_phase_next       = rx_phase_reg;
        rx_tick_count_next  = rx_tick_count_reg;
        rx_shift_next       = rx_shift_reg;
        rx_ones_parity_next = rx_ones_parity_reg;
        ring_tail_next      = ring_tail_reg;
        ring_wr             = 1'b0;
        tx_level            = 1'b1;
        tx_busy             = 1'b0;
        rx_event            = EV_NONE;
        tx_cnt_inc          = '0;
        rx_cnt_inc          = '0;
        tx_bit_off          = '0;
        rx_bit_off          = '0;
        rx_start            = 1'b0;
        rx_bad              = 1'b0;
        rx_done             = 1'b0;

        // The pop comes first in the tick; the receiver may push afterwards.
        read_data      = rd_valid_reg ? rd_q_reg : 8'h00;
        char_available = (ring_head_reg != ring_tail_reg);
        ring_head_next = (read_req && char_available) ? ring_nxt(ring_head_reg)
                                                      : ring_head_reg;

        if (!enable_reg) begin
            tx_phase_next      = PH_IDLE;
            tx_tick_count_next = '0;
            rx_phase_next      = PH_IDLE;
            rx_tick_count_next = '0;
        end else begin
            // Transmitter: a request taken while idle drives its start bit
            // in the same tick.
            if (tx_phase_reg == PH_IDLE || tx_phase_reg > PH_STOP) begin
                tx_phase_next = PH_IDLE;
                if (send_valid) begin
                    tx_shift_next      = send_byte;
                    tx_parity_bit_next = (^send_byte) ^ parity_mode_reg[0];
                    tx_phase_next      = PH_START;
                    tx_tick_count_next = '0;
                end
            end
            if (tx_phase_next != PH_IDLE) begin
                tx_bit_off = tx_phase_next - PH_DATA0;
                if (tx_phase_next == PH_START) begin
                    tx_level = 1'b0;
                end else if (tx_phase_next <= PH_DATA7) begin
                    tx_level = tx_shift_next[tx_bit_off[2:0]];
                end else if (tx_phase_next == PH_PARITY) begin
                    tx_level = tx_parity_bit_next;
                end else begin
                    tx_level = 1'b1;
                end
                tx_busy    = 1'b1;
                tx_cnt_inc = tx_tick_count_next + 1'b1;
                if (CMP_W'(tx_cnt_inc) >= CMP_W'(eff_period)) begin
                    tx_tick_count_next = '0;
                    if (tx_phase_next == PH_DATA7) begin
                        tx_phase_next = (parity_mode_reg != PAR_NONE) ? PH_PARITY : PH_STOP;
                    end else if (tx_phase_next == PH_STOP) begin
                        tx_phase_next = PH_IDLE;
                    end else begin
                        tx_phase_next = tx_phase_next + 1'b1;
                    end
                end else begin
                    tx_tick_count_next = tx_cnt_inc;
                end
            end

            // Receiver: a frame starts on a falling edge, or on a low line
            // in the tick right after a frame.
            if (rx_phase_reg == PH_IDLE || rx_phase_reg >= PH_AFTER) begin
                rx_start = !rx_level && (rx_phase_reg == PH_AFTER || rx_prev_level_reg);
                rx_tick_count_next = '0;
                if (rx_start) begin
                    rx_phase_next       = PH_START;
                    rx_shift_next       = '0;
                    rx_ones_parity_next = 1'b0;
                end else begin
                    rx_phase_next = PH_IDLE;
                end
            end
            if (rx_phase_next != PH_IDLE) begin
                rx_bit_off = rx_phase_next - PH_DATA0;
                if (CMP_W'(rx_tick_count_next) == CMP_W'(samp_pos)) begin
                    if (rx_phase_next >= PH_DATA0 && rx_phase_next <= PH_DATA7) begin
                        rx_shift_next[rx_bit_off[2:0]] = rx_shift_next[rx_bit_off[2:0]]
                                                         | rx_level;
                        rx_ones_parity_next = rx_ones_parity_next ^ rx_level;
                    end else if (rx_phase_next == PH_PARITY) begin
                        rx_ones_parity_next = rx_ones_parity_next ^ rx_level;
                    end else if (rx_phase_next == PH_STOP) begin
                        rx_bad = !rx_level
                              || ((parity_mode_reg != PAR_NONE)
                                  && (rx_ones_parity_next ^ parity_mode_reg[0]));
                        if (rx_bad) begin
                            rx_event = EV_ERROR;
                        end else if (ring_nxt(ring_tail_reg) != ring_head_next) begin
                            ring_wr        = 1'b1;
                            ring_tail_next = ring_nxt(ring_tail_reg);
                            rx_event       = EV_STORED;
                        end else begin
                            rx_event = EV_DROPPED;
                        end
                        rx_phase_next      = PH_AFTER;
                        rx_tick_count_next = '0;
                        rx_done            = 1'b1;
                    end
                end
                if (!rx_done) begin
                    rx_cnt_inc = rx_tick_count_next + 1'b1;
                    if (CMP_W'(rx_cnt_inc) >= CMP_W'(eff_period)) begin
                        rx_tick_count_next = '0;
                        if (rx_phase_next == PH_DATA7) begin
                            rx_phase_next = (parity_mode_reg != PAR_NONE) ? PH_PARITY
                                                                          : PH_STOP;
                        end else begin
                            rx_phase_next = rx_phase_next + 1'b1;
                        end
                    end else begin
                        rx_tick_count_next = rx_cnt_inc;
                    end
                end
            end
        end
    end

    // A byte written this tick at the next head slot must reach the read
    // register directly.
    assign rd_fwd = ring_wr && (ring_tail_reg == ring_head_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_phase_reg       <= PH_IDLE;
            tx_tick_count_reg  <= '0;
            tx_shift_reg       <= '0;
            tx_parity_bit_reg  <= 1'b0;
            rx_phase_reg       <= PH_IDLE;
            rx_tick_count_reg  <= '0;
            rx_shift_reg       <= '0;
            rx_ones_parity_reg <= 1'b0;
            rx_prev_level_reg  <= 1'b1;
            ring_head_reg      <= '0;
            ring_tail_reg      <= '0;
            rd_valid_reg       <= 1'b0;
        end else if (advance) begin
            tx_phase_reg       <= tx_phase_next;
            tx_tick_count_reg  <= tx_tick_count_next;
            tx_shift_reg       <= tx_shift_next;
            tx_parity_bit_reg  <= tx_parity_bit_next;
            rx_phase_reg       <= rx_phase_next;
            rx_tick_count_reg  <= rx_tick_count_next;
            rx_shift_reg       <= rx_shift_next;
            rx_ones_parity_reg <= rx_ones_parity_next;
            rx_prev_level_reg  <= rx_level;
            ring_head_reg      <= ring_head_next;
            ring_tail_reg      <= ring_tail_next;
            rd_valid_reg       <= ring_vld_reg[ring_head_next] || rd_fwd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring_vld_reg[i] <= 1'b0;
            end
        end else if (advance && ring_wr) begin
            ring_vld_reg[ring_tail_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ring_wr) begin
            ring_mem[ring_tail_reg] <= rx_shift_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_q_reg <= rd_fwd ? rx_shift_next : ring_mem[ring_head_next];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= {rx_event, char_available, read_data, tx_busy, tx_level};
        end
    end

`ifndef SYNTHESIS
    // A stored byte always leaves the ring non-empty after the tick.
    a_store_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && rx_event == EV_STORED |=> ring_head_reg != ring_tail_reg)
        else $error("ring empty after a stored byte");

    // With the block disabled the result shows no frame and no event.
    a_disabled_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !enable_reg |=> m_tdata_reg[1] == 1'b0 && m_tdata_reg[12:11] == EV_NONE)
        else $error("activity reported while disabled");

    // A held request is neither lost nor overwritten.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("pending request lost");
`endif

endmodule

// ===== sim/uart_transceiver_with_rx_fifo_test.sv =====
// Self-checking testbench for the UART transceiver with receive ring.
// Drives timer-tick requests with framed receive traffic, predicts every result
// with a tick-accurate model, and depends on utrx_pkg and the transceiver RTL.
`timescale 1ns / 1ps

module uart_transceiver_with_rx_fifo_test;
    import utrx_pkg::*;

    localparam int RING_DEPTH   = DEF_RING_DEPTH;
    localparam int CNT_W        = DEF_TICK_COUNT_BITS;
    // A request passes the input and output registers before it shows up as a result.
    localparam int PIPE_LATENCY = 2;
    // Length of the long receiver hold-off used to back the block up.
    localparam int LONG_HOLD    = 200;

    // One result, laid out exactly as m_tdata[12:0].
    typedef struct packed {
        rx_event_t  rx_ev;
        logic       has_char;
        logic [7:0] head_data;
        logic       tx_active;
        logic       tx_line;
    } tick_out_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // [0] rx_level, [1] send_valid, [9:2] send_byte, [10] read_req, [15:11] zero
    logic [15:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // [0] tx_level, [1] tx_busy, [9:2] read_data, [10] char_available,
    // [12:11] rx_event, [15:13] zero
    logic [15:0]          m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    uart_transceiver_with_rx_fifo #(
        .RING_DEPTH      (RING_DEPTH),
        .TICK_COUNT_BITS (CNT_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Results predicted for accepted requests, oldest first.
    tick_out_t pending_outputs[$];
    // Receive line levels still to be played into the block, one per request.
    logic      line_levels[$];

    int mismatch_count = 0;
    int result_index   = 0;

    // Shared controls for the idling of both sides.
    bit no_idle    = 1'b0;  // when set, neither side inserts random gaps
    bit hold_req   = 1'b0;  // asks the receiver for one long hold-off
    int stall_left = 0;

    // ------------------------------------------------------------------
    // Tick model of the transceiver: configuration copy and frame state.
    // ------------------------------------------------------------------
    logic             cfg_enable;
    logic [15:0]      cfg_period;
    logic [1:0]       cfg_parity;
    logic [15:0]      cfg_lead;

    phase_t           tx_ph;
    logic [7:0]       tx_sr;
    logic [CNT_W-1:0] tx_cnt;
    logic             tx_par;

    phase_t           rx_ph;
    logic [CNT_W-1:0] rx_cnt;
    logic [7:0]       rx_sr;
    logic             rx_par;
    logic             rx_prev;

    logic [7:0]       ring_mem [RING_DEPTH];
    int               ring_rd;
    int               ring_wr;

    task automatic model_reset();
        cfg_enable = 1'b0;
        cfg_period = RST_BIT_PERIOD;
        cfg_parity = PAR_NONE;
        cfg_lead   = RST_SAMPLE_LEAD;
        tx_ph   = PH_IDLE;
        tx_sr   = '0;
        tx_cnt  = '0;
        tx_par  = 1'b0;
        rx_ph   = PH_IDLE;
        rx_cnt  = '0;
        rx_sr   = '0;
        rx_par  = 1'b0;
        rx_prev = 1'b1;
        foreach (ring_mem[i]) ring_mem[i] = '0;
        ring_rd = 0;
        ring_wr = 0;
    endtask

    function automatic int ring_next(int i);
        return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
    endfunction

    // Advances the model by one timer tick and returns what the block should show.
    function automatic tick_out_t uart_tick_model(logic line, logic send, logic [7:0] data,
                                                  logic pop);
        tick_out_t   r;
        int unsigned per;
        int unsigned samp;
        logic        done;
        logic        bad;
        per  = (cfg_period == 0) ? 1 : cfg_period;
        samp = (cfg_lead >= per) ? 0 : per - 1 - cfg_lead;
        r.tx_line   = 1'b1;
        r.tx_active = 1'b0;
        r.rx_ev     = EV_NONE;
        // The head is shown before any pop; an empty ring shows its stale head.
        r.head_data = ring_mem[ring_rd];
        r.has_char  = (ring_rd != ring_wr);
        if (pop && r.has_char) ring_rd = ring_next(ring_rd);

        if (!cfg_enable) begin
            tx_ph  = PH_IDLE;
            tx_cnt = '0;
            rx_ph  = PH_IDLE;
            rx_cnt = '0;
        end else begin
            // Transmitter: a request taken while idle drives its start bit at once.
            if (tx_ph == PH_IDLE || tx_ph > PH_STOP) begin
                tx_ph = PH_IDLE;
                if (send) begin
                    tx_sr  = data;
                    tx_par = (^data) ^ cfg_parity[0];
                    tx_ph  = PH_START;
                    tx_cnt = '0;
                end
            end
            if (tx_ph != PH_IDLE) begin
                if (tx_ph == PH_START) r.tx_line = 1'b0;
                else if (tx_ph <= PH_DATA7) r.tx_line = tx_sr[tx_ph - PH_DATA0];
                else if (tx_ph == PH_PARITY) r.tx_line = tx_par;
                else r.tx_line = 1'b1;
                r.tx_active = 1'b1;
                tx_cnt = tx_cnt + 1'b1;
                if (tx_cnt >= per) begin
                    tx_cnt = '0;
                    if (tx_ph == PH_DATA7) tx_ph = (cfg_parity != PAR_NONE) ? PH_PARITY : PH_STOP;
                    else if (tx_ph == PH_STOP) tx_ph = PH_IDLE;
                    else tx_ph = tx_ph + 1'b1;
                end
            end

            // Receiver: a frame starts on a falling edge, or on a low line right
            // after the previous frame ended.
            if (rx_ph == PH_IDLE || rx_ph >= PH_AFTER) begin
                if (!line && (rx_ph == PH_AFTER || rx_prev)) begin
                    rx_ph  = PH_START;
                    rx_cnt = '0;
                    rx_sr  = '0;
                    rx_par = 1'b0;
                end else begin
                    rx_ph  = PH_IDLE;
                    rx_cnt = '0;
                end
            end
            if (rx_ph != PH_IDLE) begin
                done = 1'b0;
                if (rx_cnt == samp) begin
                    if (rx_ph >= PH_DATA0 && rx_ph <= PH_DATA7) begin
                        rx_sr[rx_ph - PH_DATA0] = rx_sr[rx_ph - PH_DATA0] | line;
                        rx_par = rx_par ^ line;
                    end else if (rx_ph == PH_PARITY) begin
                        rx_par = rx_par ^ line;
                    end else if (rx_ph == PH_STOP) begin
                        bad = !line || (cfg_parity != PAR_NONE && (rx_par ^ cfg_parity[0]));
                        if (bad) begin
                            r.rx_ev = EV_ERROR;
                        end else if (ring_next(ring_wr) != ring_rd) begin
                            ring_mem[ring_wr] = rx_sr;
                            ring_wr = ring_next(ring_wr);
                            r.rx_ev = EV_STORED;
                        end else begin
                            r.rx_ev = EV_DROPPED;
                        end
                        rx_ph  = PH_AFTER;
                        rx_cnt = '0;
                        done   = 1'b1;
                    end
                end
                if (!done) begin
                    rx_cnt = rx_cnt + 1'b1;
                    if (rx_cnt >= per) begin
                        rx_cnt = '0;
                        if (rx_ph == PH_DATA7)
                            rx_ph = (cfg_parity != PAR_NONE) ? PH_PARITY : PH_STOP;
                        else
                            rx_ph = rx_ph + 1'b1;
                    end
                end
            end
        end
        rx_prev = line;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout and the receiving side.
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result ready: mostly short random stalls, now and then a longer one, and
    // one long hold-off on request so that the block backs up into its input.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 99) < 20) begin
                m_tready <= 1'b0;
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic report_error(string msg);
        $display("[%0t] result %0d: %s", $realtime, result_index, msg);
        mismatch_count++;
    endtask

    // Every accepted result is checked field by field against the oldest
    // prediction.
    always @(posedge aclk) begin
        tick_out_t got;
        tick_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[12:0];
            if (pending_outputs.size() == 0) begin
                report_error($sformatf("result %h arrived with no request pending", m_tdata));
            end else begin
                want = pending_outputs.pop_front();
                if (got.tx_line !== want.tx_line)
                    report_error($sformatf("tx_level %b, expected %b",
                                           got.tx_line, want.tx_line));
                if (got.tx_active !== want.tx_active)
                    report_error($sformatf("tx_busy %b, expected %b",
                                           got.tx_active, want.tx_active));
                if (got.head_data !== want.head_data)
                    report_error($sformatf("read_data %h, expected %h",
                                           got.head_data, want.head_data));
                if (got.has_char !== want.has_char)
                    report_error($sformatf("char_available %b, expected %b",
                                           got.has_char, want.has_char));
                if (got.rx_ev !== want.rx_ev)
                    report_error($sformatf("rx_event %0d, expected %0d",
                                           got.rx_ev, want.rx_ev));
            end
            result_index++;
        end
    end

    // ------------------------------------------------------------------
    // Sending side.
    // ------------------------------------------------------------------
    function automatic int sender_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one timer tick as a request and predicts its result once it has
    // been accepted. The valid stays high on return so back-to-back requests
    // never drop it within a time step.
    task automatic drive_tick(logic line, logic send, logic [7:0] data, logic pop);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, pop, data, send, line};
        do @(posedge aclk); while (!s_tready);
        pending_outputs.push_back(uart_tick_model(line, send, data, pop));
    endtask

    // Stops offering requests and waits for every predicted result. The wait always
    // steps the clock, so a following request never lowers and raises the valid in
    // one step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_outputs.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_ENABLE:      cfg_enable = value[0];
            CFG_BIT_PERIOD:  cfg_period = value[15:0];
            CFG_PARITY_MODE: cfg_parity = value[1:0];
            CFG_SAMPLE_LEAD: cfg_lead   = value[15:0];
            default: ;
        endcase
    endtask

    // Registers change only once the block has drained; the frame state carries
    // over, so a new setting lands in the middle of whatever frame is running.
    task automatic reconfigure(logic en, logic [15:0] per, logic [1:0] par, logic [15:0] lead);
        wait_drained();
        repeat (PIPE_LATENCY) @(posedge aclk);
        write_reg(CFG_ENABLE, {15'b0, en});
        write_reg(CFG_BIT_PERIOD, per);
        write_reg(CFG_PARITY_MODE, {14'b0, par});
        write_reg(CFG_SAMPLE_LEAD, lead);
        cfg_we <= 1'b0;
    endtask

    task automatic push_level(logic level, int per);
        repeat (per) line_levels.push_back(level);
    endtask

    // Queues one receive frame at the current bit period and parity. Most frames
    // are clean; some carry a wrong parity bit or a low stop bit, and a few are
    // replaced by line noise. The idle run after a frame is sometimes left out so
    // that the next start bit follows the stop bit directly.
    task automatic queue_frame();
        logic [7:0] data;
        int         per;
        int         kind;
        per  = (cfg_period == 0) ? 1 : cfg_period;
        kind = $urandom_range(0, 99);
        if (kind >= 94) begin
            repeat ($urandom_range(1, 4 * per))
                line_levels.push_back(1'($urandom_range(0, 1)));
            return;
        end
        data = 8'($urandom_range(0, 255));
        push_level(1'b0, per);
        for (int k = 0; k < 8; k++) push_level(data[k], per);
        if (cfg_parity != PAR_NONE)
            push_level((^data) ^ cfg_parity[0] ^ (kind >= 75 && kind < 85), per);
        push_level(!(kind >= 85), per);
        if ($urandom_range(0, 2) != 0) push_level(1'b1, $urandom_range(1, 2 * per));
    endtask

    // Plays a stretch of ticks; the receive line carries frames or plain noise.
    task automatic run_traffic(int n_ticks, int pop_pct, int send_pct, bit framed);
        logic line;
        line_levels.delete();
        for (int i = 0; i < n_ticks; i++) begin
            if (framed) begin
                if (line_levels.size() == 0) queue_frame();
                line = line_levels.pop_front();
            end else begin
                line = 1'($urandom_range(0, 1));
            end
            drive_tick(line, $urandom_range(0, 99) < send_pct, 8'($urandom_range(0, 255)),
                       $urandom_range(0, 99) < pop_pct);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Short hand-built sequence: disabled operation right after reset, then one
    // frame each way with the shortest period, parity mode 3 and a sample lead
    // beyond the period.
    task automatic test_directed();
        // Receive frame of 0x5A, LSB first, odd parity bit of one, stop bit high.
        logic [10:0] frame_bits;
        frame_bits = {1'b1, 1'b1, 8'h5A, 1'b0};
        // While disabled the line stays high, sends are dropped, and a read of
        // the empty ring shows the reset head entry. The last tick leaves the
        // line high so that the frame below opens with a falling edge.
        drive_tick(1'b0, 1'b1, 8'hFF, 1'b1);
        drive_tick(1'b1, 1'b1, 8'h00, 1'b0);
        drive_tick(1'b1, 1'b0, 8'h3C, 1'b1);
        // A zero period acts as one tick per bit.
        reconfigure(1'b1, 16'd0, PAR_ODD_ALT, 16'hFFFF);
        // The first tick starts a transmit of 0xFF with its start bit at once;
        // the second request comes while busy and must be ignored.
        for (int i = 0; i < 11; i++)
            drive_tick(frame_bits[i], i < 2, (i == 0) ? 8'hFF : 8'h00, 1'b0);
        // Pop the stored byte, then read the empty ring.
        drive_tick(1'b1, 1'b0, 8'hA5, 1'b1);
        drive_tick(1'b1, 1'b0, 8'hA5, 1'b1);
        drive_tick(1'b1, 1'b0, 8'h00, 1'b0);
    endtask

    // Random framed traffic over a series of settings, the boundary ones first.
    task automatic test_random_traffic();
        logic [15:0] per;
        logic [15:0] lead;
        logic [1:0]  par;
        logic        en;
        int          pop_pct;
        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0: begin per = 16'd2; lead = 16'd0;    par = PAR_NONE; end
                // Lead of period minus one samples at the first slot tick.
                1: begin per = 16'd2; lead = 16'd1;    par = PAR_ODD; end
                2: begin per = 16'd3; lead = 16'hFFFF; par = PAR_EVEN; end
                default: begin
                    per  = 16'($urandom_range(1, 6));
                    lead = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(per, 16'hFFFF))
                                                       : 16'($urandom_range(0, per - 1));
                    par  = 2'($urandom_range(0, 3));
                end
            endcase
            en = (phase >= 3 && $urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
            case ($urandom_range(0, 2))
                0:       pop_pct = 3;
                1:       pop_pct = 30;
                default: pop_pct = 90;
            endcase
            // Every fourth phase runs with neither side idling.
            no_idle = (phase % 4 == 3);
            reconfigure(en, per, par, lead);
            run_traffic(50, pop_pct, 25, 1'b1);
        end
        no_idle = 1'b0;
    endtask

    // The largest period: a transmit starts and sits in its start bit, and the
    // next setting takes over in the middle of that frame.
    task automatic test_long_period();
        reconfigure(1'b1, 16'hFFFF, PAR_EVEN, 16'd0);
        run_traffic(40, 50, 50, 1'b0);
    endtask

    // No reads while frames keep arriving, so the ring fills and drops bytes.
    // The receiver holds off for a long stretch meanwhile, which backs the
    // block up into its input. The sender then pauses for every result before
    // the ring is drained.
    task automatic test_ring_overflow_backpressure();
        reconfigure(1'b1, 16'd2, PAR_NONE, 16'd0);
        no_idle  = 1'b1;
        hold_req = 1'b1;
        run_traffic(320, 0, 10, 1'b1);
        wait_drained();
        no_idle = 1'b0;
        run_traffic(60, 100, 10, 1'b1);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ENABLE;
        cfg_wdata <= '0;
        model_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic();
        test_long_period();
        test_ring_overflow_backpressure();

        // Let the last results come out, then wait on for any stray ones.
        wait_drained();
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
        if (pending_outputs.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_outputs.size()));
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/utrx_pkg.sv
rtl/uart_transceiver_with_rx_fifo.sv
sim/uart_transceiver_with_rx_fifo_test.sv
